// ===== hw/rtl/tgms_pkg.sv =====
// ----------------------------------------------------------------------------
// tgms_pkg
// Shared widths, defaults and the job record passed from front to back end.
// ----------------------------------------------------------------------------
`default_nettype none
package tgms_pkg;
   localparam int SampleW   = 24;
   localparam int SumW      = 41;
   localparam int SqW       = 64;
   localparam int CntW      = 17;
   localparam int StatW     = 24;
   localparam int FlagW     = 4;
   localparam int ProdW     = 82;
   localparam int DivisorW  = 32;
   localparam int SqrtSteps = 32;
   localparam int MulSteps  = 41;
   localparam int DivSteps  = 82;
   localparam int StepW     = 7;

   localparam int MAX_ROWS_DEFAULT    = 65536;
   localparam int SAMPLE_BITS_DEFAULT = 24;

   typedef struct packed {
      logic signed [SumW-1:0] sum_zero;
      logic signed [SumW-1:0] sum_one;
      logic [SqW-1:0]         sq_zero;
      logic [SqW-1:0]         sq_one;
      logic [CntW-1:0]        cnt_zero;
      logic [CntW-1:0]        cnt_one;
      logic [CntW-1:0]        invalid;
      logic [CntW-1:0]        rows_zero;
      logic [CntW-1:0]        rows_one;
   } job_type;
endpackage
`default_nettype wire

// ===== hw/rtl/tgms_if.sv =====
// ----------------------------------------------------------------------------
// tgms request and response channels
// Valid/ready channels carrying a sample row and a column result.
// ----------------------------------------------------------------------------
`default_nettype none
interface tgms_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] sample;
   logic        not_finite;
   logic        group;
   logic        last_row;
   modport source (output valid, sample, not_finite, group, last_row, input ready);
   modport sink   (input valid, sample, not_finite, group, last_row, output ready);
endinterface

interface tgms_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] mean_zero;
   logic [23:0] mean_one;
   logic [23:0] stddev_zero;
   logic [23:0] stddev_one;
   logic [16:0] valid_count_zero;
   logic [16:0] valid_count_one;
   logic [16:0] invalid_count;
   logic [16:0] rows_zero;
   logic [16:0] rows_one;
   logic [3:0]  undefined_flags;
   modport source (output valid, mean_zero, mean_one, stddev_zero, stddev_one,
                   valid_count_zero, valid_count_one, invalid_count, rows_zero,
                   rows_one, undefined_flags, input ready);
   modport sink   (input valid, mean_zero, mean_one, stddev_zero, stddev_one,
                   valid_count_zero, valid_count_one, invalid_count, rows_zero,
                   rows_one, undefined_flags, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tgms_front.sv =====
// ----------------------------------------------------------------------------
// tgms_front
// Accumulates sums, sums of squares and counts per group, one row a cycle while q_full is low.
// ----------------------------------------------------------------------------
`default_nettype none
module tgms_front #(
   parameter int MAX_ROWS    = tgms_pkg::MAX_ROWS_DEFAULT,
   parameter int SAMPLE_BITS = tgms_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   tgms_req_if.sink               req_if,
   input  wire logic              q_full,
   output tgms_pkg::job_type      job,
   output logic                   job_push
);
   localparam int Shift = tgms_pkg::SampleW - SAMPLE_BITS;

   tgms_pkg::job_type acc_ff, acc_in, upd;
   logic                                  accept;
   logic signed [tgms_pkg::SampleW-1:0]   x;
   logic signed [2*tgms_pkg::SampleW-1:0] x_sq;
   logic [tgms_pkg::CntW:0]               rows_total;
   logic                                  room;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && req_if.ready;
   assign x    = $signed(req_if.sample << Shift) >>> Shift;
   assign x_sq = x * x;
   assign rows_total = {1'b0, acc_ff.rows_zero} + {1'b0, acc_ff.rows_one};
   assign room = rows_total < (tgms_pkg::CntW+1)'(MAX_ROWS);

   always_comb begin
      upd = acc_ff;
      if (room) begin
         if (req_if.group) upd.rows_one  = acc_ff.rows_one + 1'b1;
         else              upd.rows_zero = acc_ff.rows_zero + 1'b1;
         if (req_if.not_finite) begin
            upd.invalid = acc_ff.invalid + 1'b1;
         end else if (req_if.group) begin
            upd.sum_one = acc_ff.sum_one + tgms_pkg::SumW'(x);
            upd.sq_one  = acc_ff.sq_one + tgms_pkg::SqW'($unsigned(x_sq));
            upd.cnt_one = acc_ff.cnt_one + 1'b1;
         end else begin
            upd.sum_zero = acc_ff.sum_zero + tgms_pkg::SumW'(x);
            upd.sq_zero  = acc_ff.sq_zero + tgms_pkg::SqW'($unsigned(x_sq));
            upd.cnt_zero = acc_ff.cnt_zero + 1'b1;
         end
      end
      acc_in = acc_ff;
      if (accept) acc_in = req_if.last_row ? '0 : upd;
   end

   assign job      = upd;
   assign job_push = accept && req_if.last_row;

   always_ff @(posedge clock) begin
      if (reset) acc_ff <= '0;
      else       acc_ff <= acc_in;
   end
endmodule
`default_nettype wire

// ===== hw/rtl/tgms_queue.sv =====
// ----------------------------------------------------------------------------
// tgms_queue
// Two-entry queue of finished columns between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none
module tgms_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  tgms_pkg::job_type      push_job,
   input  wire logic              pop,
   output tgms_pkg::job_type      head,
   output logic                   not_empty,
   output logic                   full
);
   tgms_pkg::job_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign not_empty = count_ff != 2'd0;
   assign full      = count_ff == 2'd2;
   assign head      = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/tgms_back.sv =====
// ----------------------------------------------------------------------------
// tgms_back
// Sequencer with a shared shift-add multiplier, restoring divider and
// bit-pair square root; works out mean and stddev of both groups.
// ----------------------------------------------------------------------------
`default_nettype none
module tgms_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  tgms_pkg::job_type      job,
   input  wire logic              job_valid,
   output logic                   job_pop,
   tgms_rsp_if.source             rsp_if
);
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MEAN = 7'b0000010,
      ST_MULQ = 7'b0000100,
      ST_MULS = 7'b0001000,
      ST_VDIV = 7'b0010000,
      ST_SQRT = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   localparam int PW = tgms_pkg::ProdW;
   localparam int DW = tgms_pkg::DivisorW;

   state_type state_ff, state_in;
   tgms_pkg::job_type job_ff, job_in;
   logic grp_ff, grp_in;
   logic [tgms_pkg::StepW-1:0] step_ff, step_in;
   logic [PW-1:0] mcand_ff, mcand_in, prod_ff, prod_in, nq_ff, nq_in, num_ff, num_in;
   logic [tgms_pkg::SumW-1:0] mplier_ff, mplier_in;
   logic [DW-1:0] rem_ff, rem_in, divisor_ff, divisor_in;
   logic [63:0] sv_ff, sv_in, sres_ff, sres_in, sbit_ff, sbit_in;
   logic [tgms_pkg::StatW-1:0] mean_ff [2], mean_in [2], sd_ff [2], sd_in [2];
   logic out_valid_ff, out_valid_in;
   logic [tgms_pkg::StatW-1:0] o_mean0_ff, o_mean0_in, o_mean1_ff, o_mean1_in;
   logic [tgms_pkg::StatW-1:0] o_sd0_ff, o_sd0_in, o_sd1_ff, o_sd1_in;
   logic [tgms_pkg::CntW-1:0]  o_c0_ff, o_c0_in, o_c1_ff, o_c1_in, o_inv_ff, o_inv_in;
   logic [tgms_pkg::CntW-1:0]  o_r0_ff, o_r0_in, o_r1_ff, o_r1_in;
   logic [tgms_pkg::FlagW-1:0] o_fl_ff, o_fl_in;

   logic signed [tgms_pkg::SumW-1:0] s_sel;
   logic [tgms_pkg::SumW-1:0] mag_sel, mag_one;
   logic [tgms_pkg::SqW-1:0]  q_sel;
   logic [tgms_pkg::CntW-1:0] n_sel;
   logic [DW:0]   trial;
   logic          qbit;
   logic [PW-1:0] num_step, prod_step, diff;
   logic [63:0]   sum_rb;
   logic [2*tgms_pkg::CntW-1:0] nn1;
   logic [tgms_pkg::StatW-1:0]  mean_val, sd_val;
   logic [63:0]   v_sat;

   assign s_sel   = grp_ff ? job_ff.sum_one : job_ff.sum_zero;
   assign q_sel   = grp_ff ? job_ff.sq_one  : job_ff.sq_zero;
   assign n_sel   = grp_ff ? job_ff.cnt_one : job_ff.cnt_zero;
   assign mag_sel = s_sel[tgms_pkg::SumW-1] ? -s_sel : s_sel;
   assign mag_one = job_ff.sum_one[tgms_pkg::SumW-1] ? -job_ff.sum_one : job_ff.sum_one;

   // restoring divide step
   assign trial    = {rem_ff, num_ff[PW-1]};
   assign qbit     = trial >= {1'b0, divisor_ff};
   assign num_step = {num_ff[PW-2:0], qbit};
   // shift-add multiply step
   assign prod_step = mplier_ff[0] ? prod_ff + mcand_ff : prod_ff;
   assign diff      = (nq_ff > prod_step) ? nq_ff - prod_step : '0;
   assign nn1       = n_sel * (n_sel - 1'b1);
   assign sum_rb    = sres_ff + sbit_ff;
   assign v_sat     = (|num_step[PW-1:64]) ? '1 : num_step[63:0];

   always_comb begin
      mean_val = s_sel[tgms_pkg::SumW-1] ? -num_step[tgms_pkg::StatW-1:0]
                                          : num_step[tgms_pkg::StatW-1:0];
      if (n_sel == '0) mean_val = '0;
      if (n_sel < tgms_pkg::CntW'(2))   sd_val = '0;
      else if (|sres_in[63:tgms_pkg::StatW]) sd_val = '1;
      else sd_val = sres_in[tgms_pkg::StatW-1:0];
   end

   always_comb begin
      state_in = state_ff; job_in = job_ff; grp_in = grp_ff; step_in = step_ff + 1'b1;
      mcand_in = mcand_ff; prod_in = prod_ff; nq_in = nq_ff; num_in = num_ff;
      mplier_in = mplier_ff; rem_in = rem_ff; divisor_in = divisor_ff;
      sv_in = sv_ff; sres_in = sres_ff; sbit_in = sbit_ff;
      mean_in = mean_ff; sd_in = sd_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      o_mean0_in = o_mean0_ff; o_mean1_in = o_mean1_ff; o_sd0_in = o_sd0_ff;
      o_sd1_in = o_sd1_ff; o_c0_in = o_c0_ff; o_c1_in = o_c1_ff; o_inv_in = o_inv_ff;
      o_r0_in = o_r0_ff; o_r1_in = o_r1_ff; o_fl_in = o_fl_ff;
      job_pop = 1'b0;
      unique case (state_ff) inside
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1; job_in = job; grp_in = 1'b0; step_in = '0;
               num_in = PW'(job.sum_zero[tgms_pkg::SumW-1] ? -job.sum_zero : job.sum_zero);
               rem_in = '0; divisor_in = DW'(job.cnt_zero);
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            rem_in = qbit ? DW'(trial - {1'b0, divisor_ff}) : trial[DW-1:0];
            num_in = num_step;
            if (step_ff == tgms_pkg::StepW'(tgms_pkg::DivSteps-1)) begin
               mean_in[grp_ff] = mean_val;
               mcand_in = PW'(q_sel); mplier_in = tgms_pkg::SumW'(n_sel);
               prod_in = '0; step_in = '0; state_in = ST_MULQ;
            end
         end
         ST_MULQ, ST_MULS: begin
            prod_in = prod_step; mcand_in = mcand_ff << 1; mplier_in = mplier_ff >> 1;
            if (step_ff == tgms_pkg::StepW'(tgms_pkg::MulSteps-1)) begin
               step_in = '0;
               if (state_ff == ST_MULQ) begin
                  nq_in = prod_step; mcand_in = PW'(mag_sel); mplier_in = mag_sel;
                  prod_in = '0; state_in = ST_MULS;
               end else begin
                  num_in = diff; rem_in = '0; divisor_in = nn1[DW-1:0];
                  state_in = ST_VDIV;
               end
            end
         end
         ST_VDIV: begin
            rem_in = qbit ? DW'(trial - {1'b0, divisor_ff}) : trial[DW-1:0];
            num_in = num_step;
            if (step_ff == tgms_pkg::StepW'(tgms_pkg::DivSteps-1)) begin
               sv_in = v_sat; sres_in = '0; sbit_in = 64'd1 << 62;
               step_in = '0; state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sv_ff >= sum_rb) begin
               sv_in = sv_ff - sum_rb; sres_in = (sres_ff >> 1) + sbit_ff;
            end else begin
               sres_in = sres_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            if (step_ff == tgms_pkg::StepW'(tgms_pkg::SqrtSteps-1)) begin
               sd_in[grp_ff] = sd_val; step_in = '0;
               if (!grp_ff) begin
                  grp_in = 1'b1; num_in = PW'(mag_one); rem_in = '0;
                  divisor_in = DW'(job_ff.cnt_one); state_in = ST_MEAN;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!out_valid_in) begin
               out_valid_in = 1'b1;
               o_mean0_in = mean_ff[0]; o_mean1_in = mean_ff[1];
               o_sd0_in = sd_ff[0]; o_sd1_in = sd_ff[1];
               o_c0_in = job_ff.cnt_zero; o_c1_in = job_ff.cnt_one;
               o_inv_in = job_ff.invalid; o_r0_in = job_ff.rows_zero;
               o_r1_in = job_ff.rows_one;
               o_fl_in = {job_ff.cnt_one < tgms_pkg::CntW'(2),
                          job_ff.cnt_zero < tgms_pkg::CntW'(2),
                          job_ff.cnt_one == '0, job_ff.cnt_zero == '0};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in; grp_ff <= grp_in; step_ff <= step_in;
      mcand_ff <= mcand_in; prod_ff <= prod_in; nq_ff <= nq_in; num_ff <= num_in;
      mplier_ff <= mplier_in; rem_ff <= rem_in; divisor_ff <= divisor_in;
      sv_ff <= sv_in; sres_ff <= sres_in; sbit_ff <= sbit_in;
      mean_ff <= mean_in; sd_ff <= sd_in;
      o_mean0_ff <= o_mean0_in; o_mean1_ff <= o_mean1_in; o_sd0_ff <= o_sd0_in;
      o_sd1_ff <= o_sd1_in; o_c0_ff <= o_c0_in; o_c1_ff <= o_c1_in; o_inv_ff <= o_inv_in;
      o_r0_ff <= o_r0_in; o_r1_ff <= o_r1_in; o_fl_ff <= o_fl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_if.valid            = out_valid_ff;
   assign rsp_if.mean_zero        = o_mean0_ff;
   assign rsp_if.mean_one         = o_mean1_ff;
   assign rsp_if.stddev_zero      = o_sd0_ff;
   assign rsp_if.stddev_one       = o_sd1_ff;
   assign rsp_if.valid_count_zero = o_c0_ff;
   assign rsp_if.valid_count_one  = o_c1_ff;
   assign rsp_if.invalid_count    = o_inv_ff;
   assign rsp_if.rows_zero        = o_r0_ff;
   assign rsp_if.rows_one         = o_r1_ff;
   assign rsp_if.undefined_flags  = o_fl_ff;

`ifndef SYNTHESIS
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> state_ff == ST_IDLE)
      else $error("job taken while busy");
   a_empty_mean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && o_fl_ff[0] |-> o_mean0_ff == '0 && o_sd0_ff == '0)
      else $error("empty group zero gives non-zero result");
   a_single_sd: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && o_fl_ff[3] |-> o_sd1_ff == '0)
      else $error("stddev of group one set with fewer than two samples");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/two_group_mean_stddev_accumulator.sv =====
// Takes one row per cycle while the result queue has room. A row with
// last_row closes the column; its mean and stddev for both groups are then
// worked out by the single shared arithmetic sequencer (per group: 82 divide
// steps for the mean, 2 x 41 multiply steps, 82 divide steps for the
// variance and 32 root steps) and loaded into the output registers. Two
// closed columns may wait in the queue; rows are stalled only when both
// slots are taken.
// ----------------------------------------------------------------------------
// two_group_mean_stddev_accumulator
// Grouped mean and sample standard deviation of a fixed-point column.
// ----------------------------------------------------------------------------
`default_nettype none
module two_group_mean_stddev_accumulator #(
   parameter int MAX_ROWS    = tgms_pkg::MAX_ROWS_DEFAULT,
   parameter int SAMPLE_BITS = tgms_pkg::SAMPLE_BITS_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   tgms_req_if.sink   req_if,
   tgms_rsp_if.source rsp_if
);
   tgms_pkg::job_type push_job, head_job;
   logic push, pop, not_empty, full;

   tgms_front #(.MAX_ROWS(MAX_ROWS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock(clock), .reset(reset), .req_if(req_if), .q_full(full),
      .job(push_job), .job_push(push));

   tgms_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_job(push_job),
      .pop(pop), .head(head_job), .not_empty(not_empty), .full(full));

   tgms_back u_back (
      .clock(clock), .reset(reset), .job(head_job), .job_valid(not_empty),
      .job_pop(pop), .rsp_if(rsp_if));
endmodule
`default_nettype wire
